/* rtl/core/source_token_scanner_assert.svh */
// assertion macros for the scanner rtl
`ifndef SOURCE_TOKEN_SCANNER_ASSERT_SVH
`define SOURCE_TOKEN_SCANNER_ASSERT_SVH

// antecedent true implies consequent in the same cycle
`define STS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// antecedent true implies consequent in the next cycle
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

/* rtl/core/sts_pkg.sv */
// scanner package: token kinds, keyword tables, character classes
`default_nettype none
package sts_pkg;

    localparam int STS_OFFSET_BITS = 24;
    localparam int STS_LINE_BITS   = 20;
    localparam int STS_QUEUE_AW    = 2;
    localparam int STS_KIND_BITS   = 5;
    localparam int STS_ERR_BITS    = 2;

    localparam logic [4:0] KIND_PLUS      = 5'd0;
    localparam logic [4:0] KIND_MINUS     = 5'd1;
    localparam logic [4:0] KIND_STAR      = 5'd2;
    localparam logic [4:0] KIND_SLASH     = 5'd3;
    localparam logic [4:0] KIND_BANG      = 5'd4;
    localparam logic [4:0] KIND_EQUAL     = 5'd6;
    localparam logic [4:0] KIND_GREATER   = 5'd8;
    localparam logic [4:0] KIND_LESS      = 5'd10;
    localparam logic [4:0] KIND_ERROR     = 5'd12;
    localparam logic [4:0] KIND_EOF       = 5'd13;
    localparam logic [4:0] KIND_LPAREN    = 5'd14;
    localparam logic [4:0] KIND_RPAREN    = 5'd15;
    localparam logic [4:0] KIND_LBRACE    = 5'd16;
    localparam logic [4:0] KIND_RBRACE    = 5'd17;
    localparam logic [4:0] KIND_SEMICOLON = 5'd18;
    localparam logic [4:0] KIND_COMMA     = 5'd19;
    localparam logic [4:0] KIND_DOT       = 5'd20;
    localparam logic [4:0] KIND_NUMBER    = 5'd21;
    localparam logic [4:0] KIND_STRING    = 5'd22;
    localparam logic [4:0] KIND_IDENT     = 5'd23;
    localparam logic [4:0] KIND_VAR       = 5'd24;
    localparam logic [4:0] KIND_NONE      = 5'd31;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_UNTERM     = 2'd2;

    localparam logic [1:0] KW_NONE   = 2'd0;
    localparam logic [1:0] KW_VAR    = 2'd1;
    localparam logic [1:0] KW_RETURN = 2'd2;
    localparam logic [1:0] KW_PRINT  = 2'd3;

    function automatic logic [2:0] kw_len(input logic [1:0] cand);
        case (cand)
            KW_VAR:    kw_len = 3'd3;
            KW_RETURN: kw_len = 3'd6;
            KW_PRINT:  kw_len = 3'd5;
            default:   kw_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] cand, input logic [2:0] idx);
        logic [47:0] text;
        case (cand)
            KW_VAR:    text = {24'h0, "rav"};
            KW_RETURN: text = "nruter";
            KW_PRINT:  text = {8'h0, "tnirp"};
            default:   text = 48'h0;
        endcase
        kw_char = text[idx*8 +: 8];
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        is_numeral = (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        is_word = (c == "_") || is_numeral(c) || is_letter(c);
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        case (c)
            "+":     single_kind = KIND_PLUS;
            "-":     single_kind = KIND_MINUS;
            "*":     single_kind = KIND_STAR;
            "(":     single_kind = KIND_LPAREN;
            ")":     single_kind = KIND_RPAREN;
            "{":     single_kind = KIND_LBRACE;
            "}":     single_kind = KIND_RBRACE;
            ";":     single_kind = KIND_SEMICOLON;
            ",":     single_kind = KIND_COMMA;
            ".":     single_kind = KIND_DOT;
            default: single_kind = KIND_NONE;
        endcase
    endfunction

    function automatic logic [4:0] op_kind(input logic [7:0] c, input logic with_eq);
        logic [4:0] base;
        case (c)
            "!":     base = KIND_BANG;
            "=":     base = KIND_EQUAL;
            ">":     base = KIND_GREATER;
            default: base = KIND_LESS;
        endcase
        op_kind = base + {4'd0, with_eq};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/source_token_scanner.sv */
// top level of the streaming source token scanner
`default_nettype none
// Streaming lexer: takes one source byte per beat (byte 0 ends the text) and returns
// tokens with kind, start offset, length, line and error code; last_of_run marks the final
// token a byte causes, and one byte may cause up to three. Input bytes are taken one per
// cycle while the four-entry run queue has room; the output side delivers one token per
// cycle while out_stall is low, so bytes that each close one token stream at full rate, and
// the queue drains bursts where one byte flushes two or three tokens.
module source_token_scanner #(
    parameter int OFFSET_BITS     = sts_pkg::STS_OFFSET_BITS,
    parameter int LINE_BITS       = sts_pkg::STS_LINE_BITS,
    parameter int QUEUE_ADDR_BITS = sts_pkg::STS_QUEUE_AW
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             char_code,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [4:0]                  token_kind,
    output logic [OFFSET_BITS-1:0]      start_offset,
    output logic [OFFSET_BITS-1:0]      lexeme_length,
    output logic [LINE_BITS-1:0]        line_number,
    output logic [1:0]                  error_code,
    output logic                        last_of_run
);
    import sts_pkg::*;

    localparam int RUN_BITS = 2 + LINE_BITS + 3 * (7 + 2 * OFFSET_BITS);

    logic                push_valid, queue_full, head_valid, pop;
    logic [RUN_BITS-1:0] push_data, head_data;

    sts_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .RUN_BITS    (RUN_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    sts_queue #(
        .WIDTH     (RUN_BITS),
        .ADDR_BITS (QUEUE_ADDR_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    sts_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .RUN_BITS    (RUN_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .start_offset  (start_offset),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .error_code    (error_code),
        .last_of_run   (last_of_run)
    );

endmodule
`default_nettype wire

/* rtl/core/sts_front.sv */
// scanner front: takes one byte a beat, tracks lexer state, builds a run of tokens
`default_nettype none
module sts_front #(
    parameter int OFFSET_BITS = sts_pkg::STS_OFFSET_BITS,
    parameter int LINE_BITS   = sts_pkg::STS_LINE_BITS,
    parameter int RUN_BITS    = 2 + LINE_BITS + 3 * (7 + 2 * OFFSET_BITS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          char_code,
    input  wire logic                queue_full,
    output logic                     push_valid,
    output logic [RUN_BITS-1:0]      push_data
);
    import sts_pkg::*;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_INT     = 4'd1;
    localparam logic [3:0] M_DOT     = 4'd2;
    localparam logic [3:0] M_FRAC    = 4'd3;
    localparam logic [3:0] M_STR     = 4'd4;
    localparam logic [3:0] M_IDENT   = 4'd5;
    localparam logic [3:0] M_OP      = 4'd6;
    localparam logic [3:0] M_SLASH   = 4'd7;
    localparam logic [3:0] M_COMMENT = 4'd8;

    localparam int TOK_BITS = 7 + 2 * OFFSET_BITS;

    logic [3:0]             mode_reg, mode_next;
    logic [7:0]             pend_reg, pend_next;
    logic [OFFSET_BITS-1:0] ts_reg, ts_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [4:0]             kw_reg, kw_next;

    logic [4:0]             tk_kind  [3];
    logic [1:0]             tk_err   [3];
    logic [OFFSET_BITS-1:0] tk_start [3];
    logic [OFFSET_BITS-1:0] tk_len   [3];
    logic [1:0]             n;
    logic                   disp;
    logic [OFFSET_BITS-1:0] prev;
    logic [4:0]             sk;
    logic [2:0][TOK_BITS-1:0] toks;
    logic                   accept;
    logic [7:0]             c;

    function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] from,
                                                    input logic [OFFSET_BITS-1:0] to);
        span = (to >= from) ? (to - from) : '0;
    endfunction

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign c        = char_code;

    always_comb
    begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        ts_next   = ts_reg;
        kw_next   = kw_reg;
        line_next = line_reg;
        n         = 2'd0;
        disp      = 1'b0;
        sk        = single_kind(c);
        prev      = (pos_reg != '0) ? (pos_reg - OFFSET_BITS'(1)) : '0;
        for (int i = 0; i < 3; i++)
        begin
            tk_kind[i]  = KIND_EOF;
            tk_err[i]   = ERR_NONE;
            tk_start[i] = '0;
            tk_len[i]   = '0;
        end

        case (mode_reg)
            M_INT, M_FRAC:
            begin
                if (c == "." && mode_reg == M_INT)
                    mode_next = M_DOT;
                else if (!is_numeral(c))
                begin
                    tk_kind[n] = KIND_NUMBER; tk_start[n] = ts_reg;
                    tk_len[n] = span(ts_reg, pos_reg); n = n + 2'd1;
                    disp = 1'b1;
                end
            end
            M_DOT:
            begin
                if (is_numeral(c))
                    mode_next = M_FRAC;
                else
                begin
                    tk_kind[n] = KIND_NUMBER; tk_start[n] = ts_reg;
                    tk_len[n] = span(ts_reg, prev); n = n + 2'd1;
                    tk_kind[n] = KIND_DOT; tk_start[n] = prev;
                    tk_len[n] = OFFSET_BITS'(1); n = n + 2'd1;
                    disp = 1'b1;
                end
            end
            M_STR:
            begin
                if (c == "\"")
                begin
                    tk_kind[n] = KIND_STRING; tk_start[n] = ts_reg;
                    tk_len[n] = span(ts_reg, pos_reg) + OFFSET_BITS'(1); n = n + 2'd1;
                    mode_next = M_IDLE;
                end
                else if (c == 8'd0)
                begin
                    tk_kind[n] = KIND_ERROR; tk_err[n] = ERR_UNTERM; tk_start[n] = ts_reg;
                    tk_len[n] = span(ts_reg, pos_reg); n = n + 2'd1;
                    disp = 1'b1;
                end
                else if (c == "\n" && line_reg != '1)
                    line_next = line_reg + LINE_BITS'(1);
            end
            M_IDENT:
            begin
                if (is_word(c))
                begin
                    if (kw_reg[4:3] != KW_NONE && kw_reg[2:0] < kw_len(kw_reg[4:3])
                        && kw_char(kw_reg[4:3], kw_reg[2:0]) == c)
                        kw_next = {kw_reg[4:3], kw_reg[2:0] + 3'd1};
                    else
                        kw_next = '0;
                end
                else
                begin
                    if (kw_reg[4:3] != KW_NONE && kw_reg[2:0] == kw_len(kw_reg[4:3]))
                        tk_kind[n] = KIND_VAR + {3'd0, kw_reg[4:3]} - 5'd1;
                    else
                        tk_kind[n] = KIND_IDENT;
                    tk_start[n] = ts_reg; tk_len[n] = span(ts_reg, pos_reg); n = n + 2'd1;
                    kw_next = '0;
                    disp = 1'b1;
                end
            end
            M_OP:
            begin
                if (c == "=")
                begin
                    tk_kind[n] = op_kind(pend_reg, 1'b1); tk_start[n] = ts_reg;
                    tk_len[n] = span(ts_reg, pos_reg) + OFFSET_BITS'(1); n = n + 2'd1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    tk_kind[n] = op_kind(pend_reg, 1'b0); tk_start[n] = ts_reg;
                    tk_len[n] = OFFSET_BITS'(1); n = n + 2'd1;
                    disp = 1'b1;
                end
                pend_next = 8'd0;
            end
            M_SLASH:
            begin
                if (c == "/")
                    mode_next = M_COMMENT;
                else
                begin
                    tk_kind[n] = KIND_SLASH; tk_start[n] = ts_reg;
                    tk_len[n] = OFFSET_BITS'(1); n = n + 2'd1;
                    disp = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (c == "\n")
                begin
                    if (line_reg != '1)
                        line_next = line_reg + LINE_BITS'(1);
                    mode_next = M_IDLE;
                end
                else if (c == 8'd0)
                    disp = 1'b1;
            end
            default:
                disp = 1'b1;
        endcase

        // dispatch the byte as from idle: end of input, whitespace, or the start of a new token
        if (disp)
        begin
            mode_next = M_IDLE;
            if (c == 8'd0)
            begin
                tk_kind[n] = KIND_EOF; tk_start[n] = pos_reg; tk_len[n] = '0; n = n + 2'd1;
            end
            else if (c == " " || c == "\t" || c == "\r" || c == "\n")
            begin
                if (c == "\n" && line_next != '1)
                    line_next = line_next + LINE_BITS'(1);
            end
            else
            begin
                ts_next = pos_reg;
                if (is_numeral(c))
                    mode_next = M_INT;
                else if (c == "\"")
                    mode_next = M_STR;
                else if (c == "_" || is_letter(c))
                begin
                    mode_next = M_IDENT;
                    kw_next = (c == "v") ? {KW_VAR, 3'd1} :
                              (c == "r") ? {KW_RETURN, 3'd1} :
                              (c == "p") ? {KW_PRINT, 3'd1} : 5'd0;
                end
                else if (c == "/")
                    mode_next = M_SLASH;
                else if (c == "!" || c == "=" || c == ">" || c == "<")
                begin
                    mode_next = M_OP;
                    pend_next = c;
                end
                else if (sk != KIND_NONE)
                begin
                    tk_kind[n] = sk; tk_start[n] = pos_reg;
                    tk_len[n] = OFFSET_BITS'(1); n = n + 2'd1;
                end
                else
                begin
                    tk_kind[n] = KIND_ERROR; tk_err[n] = ERR_UNEXPECTED; tk_start[n] = pos_reg;
                    tk_len[n] = OFFSET_BITS'(1); n = n + 2'd1;
                end
            end
        end

        // end of input restarts for a new text
        if (c == 8'd0)
        begin
            mode_next = M_IDLE;
            pend_next = 8'd0;
            kw_next   = '0;
            ts_next   = '0;
            pos_next  = '0;
            line_next = LINE_BITS'(1);
        end
        else
            pos_next = (pos_reg != '1) ? (pos_reg + OFFSET_BITS'(1)) : pos_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            toks[i] = {tk_kind[i], tk_err[i], tk_start[i], tk_len[i]};
    end

    assign push_valid = accept && (n != 2'd0);
    assign push_data  = {n, line_reg, toks};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pend_reg <= 8'd0;
            ts_reg   <= '0;
            pos_reg  <= '0;
            line_reg <= LINE_BITS'(1);
            kw_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            ts_reg   <= ts_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
            kw_reg   <= kw_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sts_queue.sv */
// short queue of token runs between scanner front and back
`default_nettype none
module sts_queue #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = sts_pkg::STS_QUEUE_AW
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data
);
    import sts_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0]   slot_reg [DEPTH];
    logic [ADDR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ADDR_BITS:0] count_reg;
    logic               do_pop;

    assign full       = (count_reg == (ADDR_BITS+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + ADDR_BITS'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + ADDR_BITS'(1);
            count_reg <= count_reg + (ADDR_BITS+1)'(push) - (ADDR_BITS+1)'(do_pop);
        end
    end

endmodule
`default_nettype wire

/* rtl/core/sts_back.sv */
// scanner back: unpacks queued runs and sends one token a beat through an output register
`default_nettype none
`include "source_token_scanner_assert.svh"
module sts_back #(
    parameter int OFFSET_BITS = sts_pkg::STS_OFFSET_BITS,
    parameter int LINE_BITS   = sts_pkg::STS_LINE_BITS,
    parameter int RUN_BITS    = 2 + LINE_BITS + 3 * (7 + 2 * OFFSET_BITS)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   head_valid,
    input  wire logic [RUN_BITS-1:0]    head_data,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [4:0]                  token_kind,
    output logic [OFFSET_BITS-1:0]      start_offset,
    output logic [OFFSET_BITS-1:0]      lexeme_length,
    output logic [LINE_BITS-1:0]        line_number,
    output logic [1:0]                  error_code,
    output logic                        last_of_run
);
    import sts_pkg::*;

    localparam int TOK_BITS = 7 + 2 * OFFSET_BITS;

    logic [1:0]               head_cnt;
    logic [LINE_BITS-1:0]     head_line;
    logic [2:0][TOK_BITS-1:0] head_toks;
    logic [TOK_BITS-1:0]      tok;
    logic [1:0]               idx_reg;
    logic                     load, last;

    logic                   out_valid_reg;
    logic [4:0]             kind_reg;
    logic [1:0]             err_reg;
    logic [OFFSET_BITS-1:0] start_reg, len_reg;
    logic [LINE_BITS-1:0]   line_reg;
    logic                   last_reg;

    assign {head_cnt, head_line, head_toks} = head_data;
    assign tok  = head_toks[idx_reg];
    assign last = (idx_reg == head_cnt - 2'd1);
    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            {kind_reg, err_reg, start_reg, len_reg} <= tok;
            line_reg <= head_line;
            last_reg <= last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign token_kind    = kind_reg;
    assign error_code    = err_reg;
    assign start_offset  = start_reg;
    assign lexeme_length = len_reg;
    assign line_number   = line_reg;
    assign last_of_run   = last_reg;

    `STS_ASSERT_IMPLY(a_run_nonempty, clk, rst_n, head_valid, head_cnt != 2'd0)
    `STS_ASSERT_IMPLY(a_idx_in_run, clk, rst_n, head_valid, idx_reg < head_cnt)
    `STS_ASSERT_NEXT(a_idx_wraps, clk, rst_n, pop, idx_reg == 2'd0 && last_of_run)
endmodule
`default_nettype wire
